[design/updq_pkg.sv]
// shared types and constants for the udp port demux queues block
`timescale 1ns / 1ps
package updq_pkg;

  typedef enum logic [2:0] {
    CMD_BIND   = 3'd0,
    CMD_UNBIND = 3'd1,
    CMD_RECV   = 3'd2,
    CMD_UDP    = 3'd3,
    CMD_ICMP   = 3'd4
  } cmd_e;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_IN_USE    = 4'd1,
    ST_FULL_TAB  = 4'd2,
    ST_NO_SOCK   = 4'd3,
    ST_EMPTY     = 4'd4,
    ST_ERROR     = 4'd5,
    ST_MALFORMED = 4'd6,
    ST_QFULL     = 4'd7,
    ST_IGNORED   = 4'd8
  } status_e;

  localparam logic [11:0] MinUdpFrame  = 12'd42;
  localparam logic [11:0] MinIcmpFrame = 12'd70;
  localparam logic [7:0]  VerIhlOk     = 8'h45;
  localparam logic [7:0]  ProtoUdp     = 8'd17;
  localparam logic [7:0]  IcmpUnreach  = 8'd3;
  localparam logic [15:0] UdpHdr       = 16'd8;

  // request as seen by the back part
  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] port;
    logic        malformed;
    logic        icmp_unreach;
    logic [31:0] ip_saddr;
    logic [15:0] udp_sport;
    logic [15:0] plen;
    logic [15:0] max_len;
    logic [11:0] handle;
  } req_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] payload_len;
    logic [31:0] ip_saddr;
    logic [15:0] udp_sport;
    logic [11:0] handle;
    logic        free_handle;
  } rsp_t;

endpackage

[design/udp_port_demux_queues_core.sv]
// top level of the udp port demux with per socket receive queues
//  channel | dir | fields (tdata, lsb first)
//  s_axis  | in  | command port frame_len ip_ver_ihl ip_proto icmp_type ip_saddr
//          |     | src_udp_port udp_length max_len frame_handle (152 bits)
//  m_axis  | out | status payload_len out_src_addr out_src_port out_handle
//          |     | free_handle (88 bits)
// the response is valid in the cycle after the back part accepts the request; a
// receive that reads the descriptor ram goes through the read state first
// the back part takes a new request only when idle, once its last response is taken;
// a stalled response holds it, and the front queue takes up to two more requests
// reset clears the socket table; descriptor ram is not cleared
`timescale 1ns / 1ps
module udp_port_demux_queues_core #(
  parameter int NUM_SOCKETS = 16,
  parameter int QUEUE_DEPTH = 16,
  parameter int HANDLE_BITS = 12
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // command port frame_len ip_ver_ihl ip_proto icmp_type ip_saddr src_udp_port
  // udp_length max_len frame_handle
  input  logic [151:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status payload_len out_src_addr out_src_port out_handle free_handle
  output logic [87:0]  m_axis_tdata
);
  import updq_pkg::*;

  req_t req;
  rsp_t rsp;
  logic req_valid, req_ready;

  updq_front #(.HandleBits(HANDLE_BITS)) u_front (
    .clk_i, .rst_ni,
    .valid_i(s_axis_tvalid), .ready_o(s_axis_tready),
    .command_i(s_axis_tdata[2:0]), .port_i(s_axis_tdata[18:3]),
    .frame_len_i(s_axis_tdata[30:19]), .ip_ver_ihl_i(s_axis_tdata[38:31]),
    .ip_proto_i(s_axis_tdata[46:39]), .icmp_type_i(s_axis_tdata[54:47]),
    .src_addr_i(s_axis_tdata[86:55]), .src_udp_port_i(s_axis_tdata[102:87]),
    .udp_length_i(s_axis_tdata[118:103]), .max_len_i(s_axis_tdata[134:119]),
    .frame_handle_i(s_axis_tdata[146:135]),
    .req_valid_o(req_valid), .req_ready_i(req_ready), .req_o(req)
  );

  updq_back #(.NumSockets(NUM_SOCKETS), .QueueDepth(QUEUE_DEPTH)) u_back (
    .clk_i, .rst_ni,
    .req_valid_i(req_valid), .req_ready_o(req_ready), .req_i(req),
    .rsp_valid_o(m_axis_tvalid), .rsp_ready_i(m_axis_tready), .rsp_o(rsp)
  );

  assign m_axis_tdata = {7'd0, rsp.free_handle, rsp.handle, rsp.udp_sport,
                         rsp.ip_saddr, rsp.payload_len, rsp.status};

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> rsp.status <= ST_IGNORED)
    else $error("status out of range");
  a_ok_udp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !rsp.free_handle |-> rsp.handle == '0)
    else $error("kept frame shows a handle");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(rsp))
    else $error("response changed while stalled");
endmodule

[design/updq_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps
module updq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[design/updq_front.sv]
// front part: classifies incoming requests into a two entry queue
`timescale 1ns / 1ps
module updq_front #(
  parameter int HandleBits = 12
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  logic [2:0]     command_i,
  input  logic [15:0]    port_i,
  input  logic [11:0]    frame_len_i,
  input  logic [7:0]     ip_ver_ihl_i,
  input  logic [7:0]     ip_proto_i,
  input  logic [7:0]     icmp_type_i,
  input  logic [31:0]    src_addr_i,
  input  logic [15:0]    src_udp_port_i,
  input  logic [15:0]    udp_length_i,
  input  logic [15:0]    max_len_i,
  input  logic [11:0]    frame_handle_i,
  output logic           req_valid_o,
  input  logic           req_ready_i,
  output updq_pkg::req_t req_o
);
  import updq_pkg::*;

  req_t       ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  req_t       nr;
  logic       push, pop;
  logic [11:0] hmask;

  assign hmask = 12'((64'd1 << HandleBits) - 64'd1);

  always_comb begin
    nr.command   = command_i;
    nr.port      = port_i;
    nr.malformed = 1'b0;
    if (command_i == CMD_UDP)
      nr.malformed = (frame_len_i < MinUdpFrame) || (ip_ver_ihl_i != VerIhlOk) ||
                     (ip_proto_i != ProtoUdp);
    else if (command_i == CMD_ICMP)
      nr.malformed = frame_len_i < MinIcmpFrame;
    nr.icmp_unreach = icmp_type_i == IcmpUnreach;
    nr.ip_saddr  = src_addr_i;
    nr.udp_sport = src_udp_port_i;
    nr.plen      = (udp_length_i >= UdpHdr) ? udp_length_i - UdpHdr : 16'd0;
    nr.max_len   = max_len_i;
    nr.handle    = frame_handle_i & hmask;
  end

  assign ready_o     = cnt_q != 2'd2;
  assign push        = valid_i && ready_o;
  assign req_valid_o = cnt_q != 2'd0;
  assign pop         = req_valid_o && req_ready_i;
  assign req_o       = ent_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wp_q] <= nr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

[design/updq_back.sv]
// back part: socket table, queue pointers and descriptor memory
`timescale 1ns / 1ps
module updq_back #(
  parameter int NumSockets = 16,
  parameter int QueueDepth = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  updq_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output updq_pkg::rsp_t rsp_o
);
  import updq_pkg::*;

  localparam int SockBits = (NumSockets > 1) ? $clog2(NumSockets) : 1;
  localparam int PtrBits  = $clog2(QueueDepth);
  localparam int AddrBits = SockBits + PtrBits;
  localparam int DescBits = 12 + 16 + 32 + 16;
  localparam logic [PtrBits-1:0] PtrLast = PtrBits'(QueueDepth - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_OUT  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [NumSockets-1:0] valid_q, valid_d, err_q, err_d;
  logic [15:0]        port_q [NumSockets];
  logic [15:0]        port_d [NumSockets];
  logic [PtrBits-1:0] head_q [NumSockets];
  logic [PtrBits-1:0] head_d [NumSockets];
  logic [PtrBits-1:0] tail_q [NumSockets];
  logic [PtrBits-1:0] tail_d [NumSockets];

  rsp_t rsp_q, rsp_d;
  logic [15:0] mlen_q;

  logic hit, has_free;
  logic [SockBits-1:0] hidx, fidx;
  logic [PtrBits-1:0] nt;
  logic we;
  logic [AddrBits-1:0] waddr, raddr;
  logic [DescBits-1:0] wdata, rdata;

  // ring pointer step, wraps after the last slot
  function automatic logic [PtrBits-1:0] ptr_inc(logic [PtrBits-1:0] p);
    return (p == PtrLast) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    hit = 1'b0; hidx = '0; has_free = 1'b0; fidx = '0;
    for (int i = NumSockets - 1; i >= 0; i--) begin
      if (valid_q[i] && port_q[i] == req_i.port) begin
        hit = 1'b1; hidx = SockBits'(i);
      end
      if (!valid_q[i]) begin
        has_free = 1'b1; fidx = SockBits'(i);
      end
    end
  end

  assign nt    = ptr_inc(tail_q[hidx]);
  assign waddr = {hidx, tail_q[hidx]};
  assign raddr = {hidx, head_q[hidx]};
  assign wdata = {req_i.handle, req_i.plen, req_i.ip_saddr, req_i.udp_sport};
  assign we    = state_q == S_IDLE && req_valid_i && req_i.command == CMD_UDP &&
                 !req_i.malformed && hit && nt != head_q[hidx];

  updq_ram #(.Width(DescBits), .Depth(2 ** AddrBits)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign req_ready_o = state_q == S_IDLE;
  assign rsp_valid_o = state_q == S_OUT;
  assign rsp_o       = rsp_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req_valid_i) mlen_q <= req_i.max_len;
  end

  always_comb begin
    state_d = state_q;
    valid_d = valid_q;
    err_d   = err_q;
    port_d  = port_q;
    head_d  = head_q;
    tail_d  = tail_q;
    rsp_d   = rsp_q;
    unique case (state_q)
      S_IDLE: if (req_valid_i) begin
        rsp_d        = '0;
        rsp_d.status = ST_IGNORED;
        state_d      = S_OUT;
        unique case (req_i.command)
          CMD_BIND: begin
            if (hit) rsp_d.status = ST_IN_USE;
            else if (!has_free) rsp_d.status = ST_FULL_TAB;
            else begin
              valid_d[fidx] = 1'b1; port_d[fidx] = req_i.port;
              err_d[fidx] = 1'b0; head_d[fidx] = '0; tail_d[fidx] = '0;
              rsp_d.status = ST_OK;
            end
          end
          CMD_UNBIND: begin
            if (hit) valid_d[hidx] = 1'b0;
            rsp_d.status = ST_OK;
          end
          CMD_RECV: begin
            if (!hit) rsp_d.status = ST_NO_SOCK;
            else if (head_q[hidx] == tail_q[hidx]) begin
              if (err_q[hidx]) begin
                err_d[hidx] = 1'b0; rsp_d.status = ST_ERROR;
              end else rsp_d.status = ST_EMPTY;
            end else begin
              head_d[hidx] = ptr_inc(head_q[hidx]);
              state_d = S_READ;
            end
          end
          CMD_UDP: begin
            rsp_d.handle = req_i.handle; rsp_d.free_handle = 1'b1;
            if (req_i.malformed) rsp_d.status = ST_MALFORMED;
            else if (!hit) rsp_d.status = ST_NO_SOCK;
            else if (nt == head_q[hidx]) rsp_d.status = ST_QFULL;
            else begin
              tail_d[hidx] = nt; rsp_d.status = ST_OK;
              rsp_d.handle = '0; rsp_d.free_handle = 1'b0;
            end
          end
          CMD_ICMP: begin
            rsp_d.handle = req_i.handle; rsp_d.free_handle = 1'b1;
            if (req_i.malformed) rsp_d.status = ST_MALFORMED;
            else if (!req_i.icmp_unreach) rsp_d.status = ST_IGNORED;
            else if (!hit) rsp_d.status = ST_NO_SOCK;
            else begin
              err_d[hidx] = 1'b1; rsp_d.status = ST_OK;
            end
          end
          default: ;
        endcase
      end
      S_READ: begin
        rsp_d.status      = ST_OK;
        rsp_d.handle      = rdata[75:64];
        rsp_d.payload_len = (rdata[63:48] < mlen_q) ? rdata[63:48] : mlen_q;
        rsp_d.ip_saddr    = rdata[47:16];
        rsp_d.udp_sport   = rdata[15:0];
        rsp_d.free_handle = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: if (rsp_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      err_q   <= '0;
      rsp_q   <= '0;
      for (int i = 0; i < NumSockets; i++) begin
        port_q[i] <= '0; head_q[i] <= '0; tail_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      err_q   <= err_d;
      rsp_q   <= rsp_d;
      port_q  <= port_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
    end
  end
endmodule
